// ===== hw/rtl/bffca_pkg.sv =====
// ----------------------------------------------------------------------------
// bffca_pkg
// Operation and status codes shared by the cell allocator.
// ----------------------------------------------------------------------------
package bffca_pkg;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_RESIZE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_SPACE  = 2'd1;
	localparam logic [1:0] ST_NOT_START = 2'd2;
	localparam logic [1:0] ST_BAD_SIZE  = 2'd3;

endpackage

// ===== hw/rtl/bump_first_fit_cell_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bump_first_fit_cell_allocator_top
// Cell heap allocator: bump pointer allocation with a first-fit fallback,
// free and resize of blocks held in a single-port cell store.
//
// A request word (operation, block_size, block_address) is taken at a rising
// edge with start high and busy low. busy then stays high until the result,
// unless the request is rejected as it is taken. The result word
// (result_status, result_address, block_moved) is shown for exactly one
// cycle with done high; there is no back-pressure, the receiver takes it
// in that cycle. A new request may be issued in the done cycle. A small
// sequencer walks one cell store port:
//   rejected requests, equal-size resize: end before any cell is written
//   bump allocation: one cell written per cycle
//   free: each cell of the block is cleared in turn
//   first-fit scan: each free cell visited and each block jumped is read
//   and evaluated, then the cells found are marked; a relocating resize may
//   add a failed growth scan before it and a pass over the old block after it
// Reset clears the cell store one cell per cycle, with busy high throughout.
// ----------------------------------------------------------------------------
module bump_first_fit_cell_allocator_top #(
	parameter int HEAP_CELLS = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    operation,
	input  logic [$clog2(HEAP_CELLS):0]   block_size,
	input  logic [$clog2(HEAP_CELLS)-1:0] block_address,
	output logic                          done,
	output logic [1:0]                    result_status,
	output logic [$clog2(HEAP_CELLS)-1:0] result_address,
	output logic                          block_moved
);

	localparam int AW = $clog2(HEAP_CELLS);
	localparam int CW = AW + 1;
	localparam int EW = 1 + AW + CW;
	localparam logic [CW-1:0] HEAP_N = CW'(HEAP_CELLS);

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_CHECK   = 4'd2;
	localparam logic [3:0] S_ALLOC   = 4'd3;
	localparam logic [3:0] S_SCAN_RD = 4'd4;
	localparam logic [3:0] S_SCAN_EV = 4'd5;
	localparam logic [3:0] S_MARK    = 4'd6;
	localparam logic [3:0] S_WIPE    = 4'd7;

	localparam logic [1:0] POST_NONE   = 2'd0;
	localparam logic [1:0] POST_SHRINK = 2'd1;
	localparam logic [1:0] POST_RELOC  = 2'd2;

	logic [EW-1:0] mem [HEAP_CELLS];
	logic [EW-1:0] rd_q;

	logic [3:0]    state_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] bump_q;
	logic          done_q;

	logic [1:0]    op_q;
	logic [CW-1:0] size_q;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] stop_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] lim_q;
	logic [AW-1:0] base_q;
	logic [1:0]    post_q;
	logic          grow_q;
	logic [1:0]    status_q;
	logic [AW-1:0] raddr_q;
	logic          moved_q;

	logic          we;
	logic [AW-1:0] wa;
	logic [EW-1:0] wd;
	logic [AW-1:0] ra;

	logic          rd_valid;
	logic [AW-1:0] rd_start;
	logic [CW-1:0] rd_end;
	logic [CW-1:0] k_next;
	logic [CW-1:0] prev;
	logic          accept;

	assign rd_valid = rd_q[EW-1];
	assign rd_start = rd_q[EW-2 -: AW];
	assign rd_end   = rd_q[CW-1:0];
	assign k_next   = k_q + CW'(1);
	assign prev     = rd_end - CW'(addr_q);
	assign accept   = start && (state_q == S_IDLE);

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign result_status  = status_q;
	assign result_address = raddr_q;
	assign block_moved    = moved_q;

	// cell store port
	always_comb begin
		we = 1'b0;
		wa = k_q[AW-1:0];
		wd = '0;
		ra = (state_q == S_IDLE) ? block_address : k_q[AW-1:0];
		unique case (state_q)
			S_CLEAR, S_WIPE: we = 1'b1;
			S_MARK: begin
				we = 1'b1;
				wd = {1'b1, base_q, lim_q};
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			k_q     <= '0;
			bump_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					k_q <= k_next;
					if (k_next == HEAP_N)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						unique case (operation)
							bffca_pkg::OP_ALLOC: begin
								if (block_size == '0)
									done_q <= 1'b1;
								else
									state_q <= S_ALLOC;
							end
							bffca_pkg::OP_FREE: begin
								if (CW'(block_address) >= HEAP_N)
									done_q <= 1'b1;
								else
									state_q <= S_CHECK;
							end
							bffca_pkg::OP_RESIZE: begin
								if (block_size == '0 || CW'(block_address) >= HEAP_N)
									done_q <= 1'b1;
								else
									state_q <= S_CHECK;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_CHECK: begin
					if (!rd_valid || rd_start != addr_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (op_q == bffca_pkg::OP_FREE) begin
						k_q     <= CW'(addr_q);
						state_q <= S_WIPE;
					end else if (size_q == prev) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (size_q < prev) begin
						k_q     <= CW'(addr_q);
						state_q <= S_MARK;
					end else if (size_q - prev > HEAP_N - rd_end) begin
						state_q <= S_ALLOC;
					end else begin
						k_q     <= rd_end;
						state_q <= S_SCAN_RD;
					end
				end
				S_ALLOC: begin
					if (size_q > HEAP_N) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (size_q <= HEAP_N - bump_q) begin
						k_q     <= bump_q;
						state_q <= S_MARK;
					end else begin
						k_q     <= '0;
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_EV;
				S_SCAN_EV: begin
					if (rd_valid) begin
						if (grow_q) begin
							state_q <= S_ALLOC;
						end else if (cnt_q > HEAP_N - rd_end) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							k_q     <= rd_end;
							state_q <= S_SCAN_RD;
						end
					end else if (k_next - pos_q == cnt_q) begin
						k_q     <= grow_q ? CW'(addr_q) : pos_q;
						state_q <= S_MARK;
					end else begin
						k_q     <= k_next;
						state_q <= S_SCAN_RD;
					end
				end
				S_MARK: begin
					k_q <= k_next;
					if (k_next == lim_q) begin
						if (lim_q > bump_q)
							bump_q <= lim_q;
						case (post_q)
							POST_SHRINK: state_q <= S_WIPE;
							POST_RELOC: begin
								k_q     <= CW'(addr_q);
								state_q <= S_WIPE;
							end
							default: begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_WIPE: begin
					k_q <= k_next;
					if (k_next == lim_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request, result word and sequencer working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q     <= operation;
					size_q   <= block_size;
					addr_q   <= block_address;
					grow_q   <= 1'b0;
					post_q   <= bffca_pkg::OP_RESIZE == operation ? POST_RELOC : POST_NONE;
					raddr_q  <= '0;
					moved_q  <= 1'b0;
					status_q <= bffca_pkg::ST_OK;
					unique case (operation)
						bffca_pkg::OP_ALLOC: begin
							if (block_size == '0)
								status_q <= bffca_pkg::ST_BAD_SIZE;
						end
						bffca_pkg::OP_FREE: begin
							if (CW'(block_address) >= HEAP_N)
								status_q <= bffca_pkg::ST_NOT_START;
						end
						bffca_pkg::OP_RESIZE: begin
							if (block_size == '0)
								status_q <= bffca_pkg::ST_BAD_SIZE;
							else if (CW'(block_address) >= HEAP_N)
								status_q <= bffca_pkg::ST_NOT_START;
						end
						default: status_q <= bffca_pkg::ST_BAD_SIZE;
					endcase
				end
			end
			S_CHECK: begin
				stop_q <= rd_end;
				if (!rd_valid || rd_start != addr_q) begin
					status_q <= bffca_pkg::ST_NOT_START;
				end else if (op_q == bffca_pkg::OP_FREE) begin
					lim_q <= rd_end;
				end else if (size_q == prev) begin
					raddr_q <= addr_q;
				end else if (size_q < prev) begin
					raddr_q <= addr_q;
					base_q  <= addr_q;
					lim_q   <= CW'(addr_q) + size_q;
					post_q  <= POST_SHRINK;
				end else begin
					pos_q  <= rd_end;
					cnt_q  <= size_q - prev;
					grow_q <= 1'b1;
				end
			end
			S_ALLOC: begin
				grow_q <= 1'b0;
				cnt_q  <= size_q;
				pos_q  <= '0;
				if (size_q > HEAP_N) begin
					status_q <= bffca_pkg::ST_NO_SPACE;
				end else if (size_q <= HEAP_N - bump_q) begin
					base_q  <= bump_q[AW-1:0];
					lim_q   <= bump_q + size_q;
					raddr_q <= bump_q[AW-1:0];
					moved_q <= (op_q == bffca_pkg::OP_RESIZE);
				end
			end
			S_SCAN_EV: begin
				if (rd_valid) begin
					if (!grow_q) begin
						pos_q <= rd_end;
						if (cnt_q > HEAP_N - rd_end)
							status_q <= bffca_pkg::ST_NO_SPACE;
					end
				end else if (k_next - pos_q == cnt_q) begin
					if (grow_q) begin
						base_q  <= addr_q;
						lim_q   <= CW'(addr_q) + size_q;
						raddr_q <= addr_q;
						post_q  <= POST_NONE;
					end else begin
						base_q  <= pos_q[AW-1:0];
						lim_q   <= pos_q + cnt_q;
						raddr_q <= pos_q[AW-1:0];
						moved_q <= (op_q == bffca_pkg::OP_RESIZE);
					end
				end
			end
			S_MARK: begin
				if (k_next == lim_q)
					lim_q <= stop_q;
			end
			default: begin
				stop_q <= stop_q;
			end
		endcase
	end

endmodule
